@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the configuration header RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/pcihdr_pkg.sv @@
// Types, constants and helper functions of the type-0 configuration header.
// Used by pcihdr_exec and pci_endpoint_config_header; depends on nothing.
package pcihdr_pkg;

	localparam int NUM_BARS    = 6;
	localparam int SPACE_BYTES = 256;
	localparam int BASE_WORDS  = 3;
	localparam int CFG_ADDR_W  = 6;
	localparam int MEM_EN_BIT  = 1;
	localparam int INTX_DIS_BIT = 2;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_IRQ   = 2'd2;

	localparam logic [2:0] CFG_IDENT_LOW    = 3'd0;
	localparam logic [2:0] CFG_IDENT_HIGH   = 3'd1;
	localparam logic [2:0] CFG_SUBSYSTEM_ID = 3'd2;
	localparam logic [2:0] CFG_INT_PIN      = 3'd3;
	localparam logic [2:0] CFG_BAR_SIZES    = 3'd4;
	localparam logic [2:0] CFG_BAR_BASES_01 = 3'd5;
	localparam logic [2:0] CFG_BAR_BASES_23 = 3'd6;
	localparam logic [2:0] CFG_BAR_BASES_45 = 3'd7;

	localparam logic [7:0] OFF_CMD_LOW  = 8'h04;
	localparam logic [7:0] OFF_CMD_HIGH = 8'h05;
	localparam logic [7:0] OFF_IDENT_HI = 8'h08;
	localparam logic [7:0] OFF_BAR_FIRST = 8'h10;
	localparam logic [7:0] OFF_BAR_END  = 8'h28;
	localparam logic [7:0] OFF_SUBSYS   = 8'h2C;
	localparam logic [7:0] OFF_SUBSYS_END = 8'h2F;
	localparam logic [7:0] OFF_INT_LINE = 8'h3C;
	localparam logic [7:0] OFF_INT_PIN  = 8'h3D;
	localparam logic [7:0] OFF_HOOK     = 8'h40;

	localparam logic [7:0] CMD_LOW_KEEP  = 8'h06;
	localparam logic [7:0] CMD_HIGH_KEEP = 8'h04;
	localparam logic [4:0] BAR_MIN_LOG2  = 5'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  offset;
		logic [2:0]  size_bytes;
		logic [31:0] data;
		logic        dev_level;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_out;
		logic        mem_enable;
	} rsp_item_t;

	typedef struct packed {
		logic [63:0] ident_low;
		logic [63:0] ident_high;
		logic [31:0] subsystem_id;
		logic [2:0]  int_pin;
		logic [29:0] bar_sizes;
	} cfg_t;

	typedef struct packed {
		logic [7:0]                 command_low;
		logic [7:0]                 command_high;
		logic [7:0]                 interrupt_line;
		logic [NUM_BARS-1:0][31:0]  bar_base;
		logic [NUM_BARS-1:0]        bar_probing;
		logic                       irq_pending;
	} state_t;

	function automatic logic [4:0] bar_log2(logic [29:0] sizes, logic [2:0] idx);
		logic [4:0] v;
		v = '0;
		for (int k = 0; k < NUM_BARS; k++) begin
			if (idx == 3'(k))
				v = sizes[5*k +: 5];
		end
		return (v < BAR_MIN_LOG2) ? 5'd0 : v;
	endfunction

	function automatic logic [31:0] align_mask(logic [4:0] lg);
		return 32'hFFFF_FFFF << lg;
	endfunction

	function automatic logic [31:0] load_base(logic [29:0] sizes, logic [31:0] base,
			logic [2:0] idx);
		logic [4:0] lg;
		lg = bar_log2(sizes, idx);
		return (lg == 5'd0) ? 32'd0 : (base & align_mask(lg));
	endfunction

	function automatic logic access_ok(logic [7:0] off, logic [2:0] sz);
		logic [8:0] end_b;
		logic       sz_ok;
		logic       aligned;
		end_b   = {1'b0, off} + {6'd0, sz};
		sz_ok   = (sz == 3'd1) || (sz == 3'd2) || (sz == 3'd4);
		aligned = !((sz == 3'd2) && off[0]) && !((sz == 3'd4) && (off[1:0] != 2'd0));
		return sz_ok && aligned && (end_b <= 9'(SPACE_BYTES));
	endfunction

	function automatic logic [7:0] header_byte(logic [7:0] off, cfg_t cfg, state_t st);
		logic [7:0]  b;
		logic [7:0]  rel;
		logic [2:0]  bar;
		logic [4:0]  lg;
		logic [31:0] w;
		rel = off - OFF_BAR_FIRST;
		bar = rel[4:2];
		lg  = bar_log2(cfg.bar_sizes, bar);
		w   = '0;
		for (int k = 0; k < NUM_BARS; k++) begin
			if (bar == 3'(k))
				w = st.bar_probing[k] ? align_mask(lg) : st.bar_base[k];
		end
		b = '0;
		if (off == OFF_CMD_LOW)
			b = st.command_low;
		else if (off == OFF_CMD_HIGH)
			b = st.command_high;
		else if (off < OFF_IDENT_HI)
			b = cfg.ident_low[{off[2:0], 3'b000} +: 8];
		else if (off < OFF_BAR_FIRST)
			b = cfg.ident_high[{off[2:0], 3'b000} +: 8];
		else if (off inside {[OFF_BAR_FIRST:OFF_BAR_END - 8'd1]})
			b = (lg == 5'd0) ? 8'd0 : w[{off[1:0], 3'b000} +: 8];
		else if (off inside {[OFF_SUBSYS:OFF_SUBSYS_END]})
			b = cfg.subsystem_id[{off[1:0], 3'b000} +: 8];
		else if (off == OFF_INT_LINE)
			b = st.interrupt_line;
		else if (off == OFF_INT_PIN)
			b = {5'd0, cfg.int_pin};
		return b;
	endfunction

endpackage

@@ hw/rtl/pcihdr_exec.sv @@
// Access logic of the configuration header: read assembly and state update for one item.
// Purely combinational; depends on pcihdr_pkg.
module pcihdr_exec (
	input  pcihdr_pkg::req_item_t item,
	input  pcihdr_pkg::cfg_t      cfg,
	input  pcihdr_pkg::state_t    st,
	output pcihdr_pkg::state_t    st_nx,
	output pcihdr_pkg::rsp_item_t rsp
);

	logic        ok;
	logic [31:0] rd;
	logic [7:0]  rel;
	logic [2:0]  bar;
	logic [4:0]  lg;
	logic [31:0] mask;
	logic [4:0]  shift;
	logic [7:0]  o;
	logic [7:0]  bv;
	logic        in_bars;

	always_comb begin
		st_nx   = st;
		ok      = pcihdr_pkg::access_ok(item.offset, item.size_bytes);
		rel     = item.offset - pcihdr_pkg::OFF_BAR_FIRST;
		bar     = rel[4:2];
		lg      = pcihdr_pkg::bar_log2(cfg.bar_sizes, bar);
		shift   = {item.offset[1:0], 3'b000};
		in_bars = item.offset inside {[pcihdr_pkg::OFF_BAR_FIRST:pcihdr_pkg::OFF_BAR_END - 8'd1]};
		o       = '0;
		bv      = '0;
		rd      = '0;
		case (item.size_bytes)
			3'd1:    mask = 32'h0000_00FF;
			3'd2:    mask = 32'h0000_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase

		case (item.action)
			pcihdr_pkg::ACT_READ: begin
				if (!ok)
					rd = 32'hFFFF_FFFF;
				else begin
					for (int i = 0; i < 4; i++) begin
						if (3'(i) < item.size_bytes)
							rd[8*i +: 8] = pcihdr_pkg::header_byte(item.offset + 8'(i), cfg, st);
					end
				end
			end
			pcihdr_pkg::ACT_WRITE: begin
				if (ok && item.offset < pcihdr_pkg::OFF_HOOK) begin
					if (in_bars) begin
						for (int k = 0; k < pcihdr_pkg::NUM_BARS; k++) begin
							if (bar == 3'(k) && lg != 5'd0) begin
								if (item.size_bytes == 3'd4 && item.data == 32'hFFFF_FFFF)
									st_nx.bar_probing[k] = 1'b1;
								else begin
									st_nx.bar_probing[k] = 1'b0;
									st_nx.bar_base[k] = ((st.bar_base[k] & ~(mask << shift))
										| ((item.data & mask) << shift))
										& pcihdr_pkg::align_mask(lg);
								end
							end
						end
					end else begin
						for (int i = 0; i < 4; i++) begin
							if (3'(i) < item.size_bytes) begin
								o  = item.offset + 8'(i);
								bv = item.data[8*i +: 8];
								if (o == pcihdr_pkg::OFF_CMD_LOW)
									st_nx.command_low = bv & pcihdr_pkg::CMD_LOW_KEEP;
								else if (o == pcihdr_pkg::OFF_CMD_HIGH)
									st_nx.command_high = bv & pcihdr_pkg::CMD_HIGH_KEEP;
								else if (o == pcihdr_pkg::OFF_INT_LINE)
									st_nx.interrupt_line = bv;
							end
						end
					end
				end
			end
			pcihdr_pkg::ACT_IRQ: st_nx.irq_pending = item.dev_level;
			default: ;
		endcase

		rsp.read_data  = rd;
		rsp.irq_out    = st_nx.irq_pending && !st_nx.command_high[pcihdr_pkg::INTX_DIS_BIT];
		rsp.mem_enable = st_nx.command_low[pcihdr_pkg::MEM_EN_BIT];
	end

endmodule

@@ hw/rtl/pci_endpoint_config_header.sv @@
// Top level of the type-0 configuration header of one endpoint.
// Instantiates pcihdr_exec; depends on pcihdr_pkg and assert_macros.svh.
//
// Usage:
//   req channel (req_valid, req_stall, req): one item per accepted cycle, a
//   config read, a config write or a new device interrupt level.
//   rsp channel (rsp_valid, rsp_stall, rsp): exactly one result per item, in
//   order: read data (all ones on an invalid read, zero for other actions),
//   the masked interrupt and the memory enable after the item.
//   APB port: identity words, subsystem id, interrupt pin, BAR sizes and
//   initial bases at byte address 8*i; 64-bit data; pready is tied high.
//   Writing the BAR sizes or bases reloads every BAR base and clears probes.
// Timing: an accepted item is held in the input register, executed from there
//   into the output register, where rsp_valid rises and the result can be taken;
//   one item per cycle is sustained while rsp_stall is low. The input register
//   and the output register are the only stages.
// Reset clears command, interrupt line, pending interrupt, probes, BAR bases
//   and all configuration. While rsp_stall is high the output holds and the
//   input register keeps one more item, then req_stall rises.
`include "assert_macros.svh"

module pci_endpoint_config_header (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  pcihdr_pkg::req_item_t               req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output pcihdr_pkg::rsp_item_t               rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pcihdr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [63:0]                         pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);

	pcihdr_pkg::req_item_t item_s1;
	logic                  valid_s1;
	pcihdr_pkg::rsp_item_t rsp_q;
	logic                  rsp_valid_q;
	pcihdr_pkg::state_t    st_q;
	pcihdr_pkg::state_t    st_d;
	pcihdr_pkg::state_t    exec_st;
	pcihdr_pkg::rsp_item_t exec_rsp;
	pcihdr_pkg::cfg_t      cfg_q;
	pcihdr_pkg::cfg_t      cfg_d;
	logic [pcihdr_pkg::BASE_WORDS-1:0][63:0] bases_q;
	logic [pcihdr_pkg::BASE_WORDS-1:0][63:0] bases_d;
	logic                  reload;
	logic                  advance;
	logic                  accept;
	logic                  cfg_we;
	logic [2:0]            cfg_idx;

	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite && pready;
	assign cfg_idx   = paddr[5:3];
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pcihdr_exec u_exec (
		.item  (item_s1),
		.cfg   (cfg_q),
		.st    (st_q),
		.st_nx (exec_st),
		.rsp   (exec_rsp)
	);

	always_comb begin
		cfg_d   = cfg_q;
		bases_d = bases_q;
		reload  = 1'b0;
		if (cfg_we) begin
			case (cfg_idx)
				pcihdr_pkg::CFG_IDENT_LOW:    cfg_d.ident_low = pwdata;
				pcihdr_pkg::CFG_IDENT_HIGH:   cfg_d.ident_high = pwdata;
				pcihdr_pkg::CFG_SUBSYSTEM_ID: cfg_d.subsystem_id = pwdata[31:0];
				pcihdr_pkg::CFG_INT_PIN:      cfg_d.int_pin = pwdata[2:0];
				pcihdr_pkg::CFG_BAR_SIZES: begin
					cfg_d.bar_sizes = pwdata[29:0];
					reload = 1'b1;
				end
				pcihdr_pkg::CFG_BAR_BASES_01: begin
					bases_d[0] = pwdata;
					reload = 1'b1;
				end
				pcihdr_pkg::CFG_BAR_BASES_23: begin
					bases_d[1] = pwdata;
					reload = 1'b1;
				end
				pcihdr_pkg::CFG_BAR_BASES_45: begin
					bases_d[2] = pwdata;
					reload = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		st_d = advance ? exec_st : st_q;
		if (reload) begin
			for (int k = 0; k < pcihdr_pkg::NUM_BARS; k++) begin
				st_d.bar_base[k] = pcihdr_pkg::load_base(cfg_d.bar_sizes,
					bases_d[k >> 1][32*(k & 1) +: 32], 3'(k));
				st_d.bar_probing[k] = 1'b0;
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			pcihdr_pkg::CFG_IDENT_LOW:    prdata = cfg_q.ident_low;
			pcihdr_pkg::CFG_IDENT_HIGH:   prdata = cfg_q.ident_high;
			pcihdr_pkg::CFG_SUBSYSTEM_ID: prdata = {32'd0, cfg_q.subsystem_id};
			pcihdr_pkg::CFG_INT_PIN:      prdata = {61'd0, cfg_q.int_pin};
			pcihdr_pkg::CFG_BAR_SIZES:    prdata = {34'd0, cfg_q.bar_sizes};
			pcihdr_pkg::CFG_BAR_BASES_01: prdata = bases_q[0];
			pcihdr_pkg::CFG_BAR_BASES_23: prdata = bases_q[1];
			pcihdr_pkg::CFG_BAR_BASES_45: prdata = bases_q[2];
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			st_q        <= '0;
			cfg_q       <= '0;
			bases_q     <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			st_q    <= st_d;
			cfg_q   <= cfg_d;
			bases_q <= bases_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= req;
		if (advance)
			rsp_q <= exec_rsp;
	end

	`ASSERT_ALWAYS(a_stall_when_blocked, !(valid_s1 && rsp_valid_q && rsp_stall) || req_stall, "item register not held while output is blocked")
	`ASSERT_NEXT(a_output_drains, rsp_valid_q && !rsp_stall && !advance, !rsp_valid_q, "result delivered twice")
	`ASSERT_NEXT(a_reload_clears_probe, cfg_we && (cfg_idx == pcihdr_pkg::CFG_BAR_SIZES), st_q.bar_probing == '0, "BAR probe survived a size change")

endmodule

@@ bench/tb_pci_endpoint_config_header.sv @@
// Testbench for pci_endpoint_config_header: directed, configuration and random item tests.
// Predicts every result with its own model of the header and checks results in order.
// Depends on pcihdr_pkg and the RTL top level only.
module tb_pci_endpoint_config_header;
	timeunit 1ns;
	timeprecision 1ps;

	import pcihdr_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	pci_endpoint_config_header i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// configuration as written through the APB port
	logic [63:0] cfg_ident_lo = '0;
	logic [63:0] cfg_ident_hi = '0;
	logic [31:0] cfg_subsys = '0;
	logic [2:0]  cfg_pin = '0;
	logic [29:0] cfg_sizes = '0;
	logic [63:0] cfg_bases [0:2] = '{default: '0};

	// header state
	logic [7:0]  cmd_lo = '0;
	logic [7:0]  cmd_hi = '0;
	logic [7:0]  int_line = '0;
	logic [31:0] bar_base [0:NUM_BARS-1] = '{default: '0};
	logic        bar_probe [0:NUM_BARS-1] = '{default: 1'b0};
	logic        irq_pend = 1'b0;

	rsp_item_t rsp_due [$];
	rsp_item_t want_rsp;
	int mismatches = 0;
	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [4:0] bar_lg(int b);
		logic [4:0] v;
		if (b >= NUM_BARS)
			return 5'd0;
		v = cfg_sizes[5*b +: 5];
		return (v < BAR_MIN_LOG2) ? 5'd0 : v;
	endfunction

	function automatic void reload_bars();
		logic [4:0]  lg;
		logic [31:0] b;
		for (int i = 0; i < NUM_BARS; i++) begin
			lg = bar_lg(i);
			b = cfg_bases[i/2][32*(i%2) +: 32];
			bar_base[i] = (lg != 5'd0) ? (b & (ALL_ONES << lg)) : 32'd0;
			bar_probe[i] = 1'b0;
		end
	endfunction

	function automatic void cfg_apply(logic [2:0] idx, logic [63:0] val);
		case (idx)
			CFG_IDENT_LOW: cfg_ident_lo = val;
			CFG_IDENT_HIGH: cfg_ident_hi = val;
			CFG_SUBSYSTEM_ID: cfg_subsys = val[31:0];
			CFG_INT_PIN: cfg_pin = val[2:0];
			CFG_BAR_SIZES: begin
				cfg_sizes = val[29:0];
				reload_bars();
			end
			CFG_BAR_BASES_01: begin
				cfg_bases[0] = val;
				reload_bars();
			end
			CFG_BAR_BASES_23: begin
				cfg_bases[1] = val;
				reload_bars();
			end
			CFG_BAR_BASES_45: begin
				cfg_bases[2] = val;
				reload_bars();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] hdr_byte(int o);
		int          b;
		logic [4:0]  lg;
		logic [31:0] w;
		if (o == OFF_CMD_LOW)
			return cmd_lo;
		if (o == OFF_CMD_HIGH)
			return cmd_hi;
		if (o < OFF_IDENT_HI)
			return cfg_ident_lo[8*o +: 8];
		if (o < OFF_BAR_FIRST)
			return cfg_ident_hi[8*(o-8) +: 8];
		if (o < OFF_BAR_END) begin
			b = (o - OFF_BAR_FIRST) / 4;
			lg = bar_lg(b);
			if (lg == 5'd0)
				return 8'd0;
			w = bar_probe[b] ? (ALL_ONES << lg) : bar_base[b];
			return w[8*(o%4) +: 8];
		end
		if (o >= OFF_SUBSYS && o <= OFF_SUBSYS_END)
			return cfg_subsys[8*(o-OFF_SUBSYS) +: 8];
		if (o == OFF_INT_LINE)
			return int_line;
		if (o == OFF_INT_PIN)
			return {5'd0, cfg_pin};
		return 8'd0;
	endfunction

	// advance the header by one item and return the result it causes
	function automatic rsp_item_t header_access(req_item_t it);
		rsp_item_t   r;
		int          o;
		int          sz;
		int          b;
		int          sh;
		logic [4:0]  lg;
		logic [31:0] m;
		logic [7:0]  by;
		bit          ok;
		o = it.offset;
		sz = it.size_bytes;
		ok = (sz == 1 || sz == 2 || sz == 4) && (o % sz == 0) && (o + sz <= SPACE_BYTES);
		r = '0;
		if (it.action == ACT_READ) begin
			if (!ok)
				r.read_data = ALL_ONES;
			else
				for (int i = 0; i < sz; i++)
					r.read_data[8*i +: 8] = hdr_byte(o + i);
		end else if (it.action == ACT_WRITE && ok && o < OFF_HOOK) begin
			if (o >= OFF_BAR_FIRST && o < OFF_BAR_END) begin
				b = (o - OFF_BAR_FIRST) / 4;
				lg = bar_lg(b);
				sh = 8 * (o % 4);
				if (lg != 5'd0) begin
					if (sz == 4 && it.data == ALL_ONES)
						bar_probe[b] = 1'b1;
					else begin
						bar_probe[b] = 1'b0;
						m = ALL_ONES >> (32 - 8*sz);
						bar_base[b] = ((bar_base[b] & ~(m << sh)) | ((it.data & m) << sh))
							& (ALL_ONES << lg);
					end
				end
			end else
				for (int i = 0; i < sz; i++) begin
					by = it.data[8*i +: 8];
					if (o + i == OFF_CMD_LOW)
						cmd_lo = by & CMD_LOW_KEEP;
					else if (o + i == OFF_CMD_HIGH)
						cmd_hi = by & CMD_HIGH_KEEP;
					else if (o + i == OFF_INT_LINE)
						int_line = by;
				end
		end else if (it.action == ACT_IRQ)
			irq_pend = it.dev_level;
		r.irq_out = irq_pend && !cmd_hi[INTX_DIS_BIT];
		r.mem_enable = cmd_lo[MEM_EN_BIT];
		return r;
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: rd=%h irq=%b mem=%b",
						rsp.read_data, rsp.irq_out, rsp.mem_enable);
			end else begin
				want_rsp = rsp_due.pop_front();
				if (rsp.read_data !== want_rsp.read_data || rsp.irq_out !== want_rsp.irq_out
						|| rsp.mem_enable !== want_rsp.mem_enable) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected rd=%h irq=%b mem=%b, got rd=%h irq=%b mem=%b",
							want_rsp.read_data, want_rsp.irq_out, want_rsp.mem_enable,
							rsp.read_data, rsp.irq_out, rsp.mem_enable);
				end
			end
		end
	end

	function automatic req_item_t mk(logic [1:0] a, logic [7:0] o, logic [2:0] s,
			logic [31:0] d, logic lvl);
		req_item_t it;
		it.action = a;
		it.offset = o;
		it.size_bytes = s;
		it.data = d;
		it.dev_level = lvl;
		return it;
	endfunction

	task automatic send_item(input req_item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall);
		rsp_due.push_back(header_access(it));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'({idx, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_apply(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_sizes();
		logic [29:0] v;
		int r;
		for (int i = 0; i < NUM_BARS; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				v[5*i +: 5] = 5'd0;
			else if (r == 1)
				v[5*i +: 5] = 5'($urandom_range(1, 3));
			else
				v[5*i +: 5] = 5'($urandom_range(4, (r > 7) ? 31 : 12));
		end
		return {$urandom, 2'($urandom), v};
	endfunction

	function automatic req_item_t rand_req();
		req_item_t it;
		int r;
		it.data = $urandom;
		it.dev_level = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		it.action = (r < 40) ? ACT_READ : (r < 85) ? ACT_WRITE : (r < 97) ? ACT_IRQ : ACT_NONE;
		if ($urandom_range(0, 99) < 85)
			it.size_bytes = 3'(1 << $urandom_range(0, 2));
		else
			it.size_bytes = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 40)
			it.offset = 8'($urandom_range(0, 63));
		else if (r < 80)
			it.offset = 8'($urandom_range(OFF_BAR_FIRST, OFF_BAR_END - 1));
		else
			it.offset = 8'($urandom);
		if ($urandom_range(0, 9) != 0) begin
			if (it.size_bytes == 3'd2)
				it.offset[0] = 1'b0;
			if (it.size_bytes == 3'd4)
				it.offset[1:0] = 2'b00;
		end
		if (it.action == ACT_WRITE && it.size_bytes == 3'd4 && it.offset >= OFF_BAR_FIRST
				&& it.offset < OFF_BAR_END && $urandom_range(0, 3) == 0)
			it.data = ALL_ONES;
		return it;
	endfunction

	// probe a BAR, read its mask, relocate it and read the new base
	task automatic probe_bar(input int b);
		logic [7:0] o;
		logic [2:0] s;
		o = 8'(OFF_BAR_FIRST + 4*b);
		s = 3'(1 << $urandom_range(0, 2));
		send_item(mk(ACT_WRITE, o, 3'd4, ALL_ONES, 1'($urandom)));
		send_item(mk(ACT_READ, o, 3'd4, $urandom, 1'($urandom)));
		send_item(mk(ACT_WRITE, o | 8'(s == 3'd1 ? $urandom_range(0, 3) :
			s == 3'd2 ? 2*$urandom_range(0, 1) : 0), s, $urandom, 1'($urandom)));
		send_item(mk(ACT_READ, o, 3'd4, $urandom, 1'($urandom)));
	endtask

	task automatic test_directed();
		apb_write(CFG_IDENT_LOW, 64'hA5C3_F00F_5A3C_10EE);
		apb_write(CFG_IDENT_HIGH, 64'h0080_4020_0C03_0001);
		apb_write(CFG_SUBSYSTEM_ID, 64'hDEAD_BEEF_CAFE_F00D);
		apb_write(CFG_INT_PIN, 64'h9);
		apb_write(CFG_BAR_SIZES, {34'd0, 5'd20, 5'd2, 5'd0, 5'd31, 5'd4, 5'd12});
		apb_write(CFG_BAR_BASES_01, 64'h8765_4321_FEDC_BA98);
		apb_write(CFG_BAR_BASES_23, 64'h1111_2222_3333_4444);
		apb_write(CFG_BAR_BASES_45, 64'hFFFF_FFFF_0000_0FFF);
		send_item(mk(ACT_READ, 8'h00, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_READ, OFF_IDENT_HI, 3'd4, ALL_ONES, 1'b1));
		send_item(mk(ACT_READ, 8'h0C, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, OFF_CMD_LOW, 3'd2, 32'h0000_FFFF, 1'b0));
		send_item(mk(ACT_READ, OFF_CMD_LOW, 3'd2, 32'h0, 1'b0));
		send_item(mk(ACT_IRQ, 8'h00, 3'd0, 32'h0, 1'b1));
		send_item(mk(ACT_WRITE, OFF_CMD_HIGH, 3'd1, 32'hFFFF_FF00, 1'b0));
		send_item(mk(ACT_WRITE, OFF_BAR_FIRST, 3'd4, ALL_ONES, 1'b0));
		send_item(mk(ACT_READ, OFF_BAR_FIRST, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_READ, 8'h11, 3'd1, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, 8'h12, 3'd2, 32'h0000_ABCD, 1'b0));
		send_item(mk(ACT_READ, OFF_BAR_FIRST, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, 8'h18, 3'd4, ALL_ONES, 1'b0));
		send_item(mk(ACT_READ, 8'h18, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, 8'h20, 3'd4, 32'h1234_5678, 1'b0));
		send_item(mk(ACT_READ, 8'h1C, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_READ, 8'h20, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, OFF_INT_LINE, 3'd2, 32'h0000_FFA5, 1'b0));
		send_item(mk(ACT_READ, OFF_INT_LINE, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_READ, OFF_SUBSYS, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_READ, 8'h01, 3'd2, 32'h0, 1'b0));
		send_item(mk(ACT_READ, 8'h00, 3'd3, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, OFF_CMD_HIGH, 3'd2, 32'h0, 1'b0));
		send_item(mk(ACT_WRITE, OFF_HOOK, 3'd4, ALL_ONES, 1'b0));
		send_item(mk(ACT_READ, 8'hFC, 3'd4, 32'h0, 1'b0));
		send_item(mk(ACT_NONE, 8'hFF, 3'd7, ALL_ONES, 1'b0));
		send_item(mk(ACT_READ, 8'hFF, 3'd1, 32'h0, 1'b0));
		send_item(mk(ACT_READ, 8'h10, 3'd0, 32'h0, 1'b0));
		wait_drained();
	endtask

	task automatic test_config_extremes();
		logic [63:0] val;
		for (int s = 0; s < 3; s++) begin
			wait_drained();
			for (int idx = 0; idx < 8; idx++) begin
				val = (s == 0) ? 64'd0 : ~64'd0;
				if (s == 2 && idx == CFG_BAR_SIZES)
					val = {34'd0, {6{5'd4}}};
				if (s == 2 && idx == CFG_INT_PIN)
					val = 64'd5;
				apb_write(3'(idx), val);
			end
			for (int o = 0; o < OFF_HOOK; o += 4)
				send_item(mk(ACT_READ, 8'(o), 3'd4, $urandom, 1'($urandom)));
			for (int b = 0; b < NUM_BARS; b++)
				probe_bar(b);
		end
		wait_drained();
	endtask

	task automatic test_random();
		int n;
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			for (int idx = 0; idx < 8; idx++)
				if ($urandom_range(0, 1) == 1)
					apb_write(3'(idx), (idx == CFG_BAR_SIZES) ? rand_sizes() :
						{$urandom, $urandom});
			gaps_on = (ph < 7) && (ph % 3 != 2);
			stalls_on = (ph < 7) && (ph % 3 != 1);
			n = 0;
			while (n < 250) begin
				if ($urandom_range(0, 9) == 0) begin
					probe_bar($urandom_range(0, NUM_BARS - 1));
					n += 4;
				end else begin
					send_item(rand_req());
					n++;
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		if (mismatches == 0 && rsp_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pcihdr_pkg.sv
hw/rtl/pcihdr_exec.sv
hw/rtl/pci_endpoint_config_header.sv
bench/tb_pci_endpoint_config_header.sv
